// File: rtl/mmnf_pkg.sv
`default_nettype none

package mmnf_pkg;

    localparam int CFG_W         = 11;
    localparam int NUM_CELLS     = 2;
    localparam int FIFO_DEPTH    = 4;
    localparam int MIN_DIM       = 2;
    localparam int WIDTH_RST     = 800;
    localparam int HEIGHT_RST    = 600;
    localparam logic [7:0] THRESHOLD_RST = 8'd10;
    localparam logic [3:0] LIMIT_RST     = 4'd8;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef enum logic [1:0] {
        REG_THRESHOLD,
        REG_LIMIT,
        REG_WIDTH,
        REG_HEIGHT
    } reg_index_t;

    typedef logic [2:0] col_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    typedef struct packed {
        logic mid;
        logic up;
    } line_pair_t;

    typedef struct packed {
        logic motion;
        logic eof;
    } result_t;

    function automatic logic [1:0] popcount3(input col_t c);
        return 2'(c[0]) + 2'(c[1]) + 2'(c[2]);
    endfunction

endpackage

`default_nettype wire

// File: rtl/motion_mask_neighbour_filter.sv
// Channel | Direction | Handshake              | Payload
// pixel   | in        | pixel_valid/pixel_stall | command, previous_pixel, current_pixel
// mask    | out       | mask_valid/mask_stall   | motion, end_of_frame
// cfg     | in        | cfg_write               | cfg_index, cfg_data
//
// One word per clock each way unless stalled; a result released by a word is
// registered, then written into a four-word output queue that sets pixel_stall.
// The first result of a stream follows frame_width + 1 pixel words.
// rst_n is asynchronous; line stores are not cleared and hold nothing useful
// until the first line has passed.
// mask_stall fills the queue; pixel_stall rises once held and pending words fill it.
`default_nettype none

module motion_mask_neighbour_filter
    import mmnf_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             pixel_valid,
    output logic                  pixel_stall,
    input  wire logic             command,
    input  wire logic [7:0]       previous_pixel,
    input  wire logic [7:0]       current_pixel,
    output logic                  mask_valid,
    input  wire logic             mask_stall,
    output logic                  motion,
    output logic                  end_of_frame,
    input  wire logic             cfg_write,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    localparam int CB = $clog2(MAX_WIDTH);
    localparam int RB = $clog2(MAX_HEIGHT);
    localparam int PB = $clog2(MAX_WIDTH + 2);
    localparam int FP = $clog2(FIFO_DEPTH);
    localparam int FC = $clog2(FIFO_DEPTH + 1);
    localparam int W_RST = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;
    localparam int H_RST = (HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RST;

    function automatic int clamp_dim(input int v, input int hi);
        if (v < MIN_DIM)
        begin
            return MIN_DIM;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    // configuration
    logic [7:0]    thr_reg;
    logic [3:0]    limit_reg;
    logic [CB-1:0] w_last_reg;
    logic [PB-1:0] pend_full_reg;
    logic [RB-1:0] h_last_reg;
    logic          restart;
    int            clamp_w;
    int            clamp_h;

    assign clamp_w = clamp_dim(int'(cfg_data), MAX_WIDTH);
    assign clamp_h = clamp_dim(int'(cfg_data), MAX_HEIGHT);
    assign restart = cfg_write && (reg_index_t'(cfg_index) == REG_WIDTH
                                   || reg_index_t'(cfg_index) == REG_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= THRESHOLD_RST;
            limit_reg     <= LIMIT_RST;
            w_last_reg    <= CB'(W_RST - 1);
            pend_full_reg <= PB'(W_RST + 1);
            h_last_reg    <= RB'(H_RST - 1);
        end
        else if (cfg_write)
        begin
            case (reg_index_t'(cfg_index))
                REG_THRESHOLD: thr_reg <= cfg_data[7:0];
                REG_LIMIT:     limit_reg <= cfg_data[3:0];
                REG_WIDTH:
                begin
                    w_last_reg    <= CB'(clamp_w - 1);
                    pend_full_reg <= PB'(clamp_w + 1);
                end
                REG_HEIGHT:    h_last_reg <= RB'(clamp_h - 1);
                default:       thr_reg <= thr_reg;
            endcase
        end
    end

    // input stage
    logic          accept;
    logic          is_flush;
    logic          pend_zero;
    logic          pend_full;
    logic [7:0]    diff;
    logic          chg;
    logic          a_emit;
    logic          a_shift;
    logic [PB-1:0] pend_reg;
    logic [PB-1:0] pend_next;
    logic [CB-1:0] in_col_reg;
    logic [CB-1:0] in_col_next;

    logic [FC-1:0] fifo_count_reg;
    logic          b_valid_reg;
    logic          b_emit_reg;
    logic          b_flush_reg;
    logic          b_chg_reg;
    logic [CB-1:0] b_addr_reg;

    assign pixel_stall = (fifo_count_reg + FC'(b_emit_reg)) >= FC'(FIFO_DEPTH);
    assign accept      = pixel_valid && !pixel_stall;
    assign is_flush    = (command == CMD_FLUSH);
    assign pend_zero   = (pend_reg == '0);
    assign pend_full   = (pend_reg == pend_full_reg);
    assign diff        = (previous_pixel > current_pixel) ? previous_pixel - current_pixel
                                                          : current_pixel - previous_pixel;
    assign chg         = diff > thr_reg;
    assign a_emit      = is_flush ? !pend_zero : pend_full;
    assign a_shift     = is_flush ? !pend_zero : 1'b1;

    always_comb
    begin
        pend_next   = pend_reg;
        in_col_next = in_col_reg;
        if (restart)
        begin
            pend_next   = '0;
            in_col_next = '0;
        end
        else if (accept)
        begin
            if (is_flush)
            begin
                if (!pend_zero)
                begin
                    pend_next = pend_reg - PB'(1);
                end
            end
            else
            begin
                if (!pend_full)
                begin
                    pend_next = pend_reg + PB'(1);
                end
                in_col_next = (in_col_reg == w_last_reg) ? '0 : in_col_reg + CB'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg    <= '0;
            in_col_reg  <= '0;
            b_valid_reg <= 1'b0;
            b_emit_reg  <= 1'b0;
        end
        else
        begin
            pend_reg    <= pend_next;
            in_col_reg  <= in_col_next;
            b_valid_reg <= accept && a_shift;
            b_emit_reg  <= accept && a_emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_flush_reg <= is_flush;
            b_chg_reg   <= chg;
            b_addr_reg  <= in_col_reg;
        end
    end

    // line stores and window
    line_pair_t rd_pair;
    line_pair_t wr_pair;
    col_t       newcol;

    assign wr_pair.mid = b_chg_reg;
    assign wr_pair.up  = rd_pair.mid;

    mmnf_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CB)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (accept && !is_flush),
        .rd_addr (in_col_reg),
        .rd_data (rd_pair),
        .wr_en   (b_valid_reg && !b_flush_reg),
        .wr_addr (b_addr_reg),
        .wr_data (wr_pair)
    );

    assign newcol = b_flush_reg ? '0 : {b_chg_reg, rd_pair.mid, rd_pair.up};

    logic [CB-1:0] out_col_reg;
    logic [RB-1:0] out_row_reg;
    logic          last_col;
    logic          last_row;
    col_t          rows_en;
    col_t          chain [NUM_CELLS+1];
    col_t          cell_mask [NUM_CELLS];
    logic [1:0]    cell_count [NUM_CELLS];
    col_t          new_mask;
    cell_ctrl_t    cell_ctrl;
    logic [3:0]    count_sum;
    result_t       res;

    assign last_col  = (out_col_reg == w_last_reg);
    assign last_row  = (out_row_reg == h_last_reg);
    assign rows_en   = {!last_row, 1'b1, out_row_reg != '0};
    assign cell_mask[0] = (out_col_reg != '0) ? rows_en : '0;
    assign cell_mask[1] = rows_en & 3'b101;
    assign new_mask  = last_col ? '0 : rows_en;
    assign chain[NUM_CELLS] = newcol;

    assign cell_ctrl.shift = b_valid_reg;
    assign cell_ctrl.clear = restart;

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        mmnf_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl),
            .col_in   (chain[i+1]),
            .row_mask (cell_mask[i]),
            .col_out  (chain[i]),
            .count    (cell_count[i])
        );
    end

    assign count_sum  = 4'(cell_count[0]) + 4'(cell_count[1])
                      + 4'(popcount3(newcol & new_mask));
    assign res.motion = chain[1][1] && (count_sum >= limit_reg);
    assign res.eof    = last_row && last_col;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (restart)
        begin
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (b_emit_reg)
        begin
            if (last_col)
            begin
                out_col_reg <= '0;
                out_row_reg <= last_row ? '0 : out_row_reg + RB'(1);
            end
            else
            begin
                out_col_reg <= out_col_reg + CB'(1);
            end
        end
    end

    // output queue
    result_t       fifo_mem [FIFO_DEPTH];
    logic [FP-1:0] wr_ptr_reg;
    logic [FP-1:0] rd_ptr_reg;
    logic          pop;

    assign pop = mask_valid && !mask_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end
        else
        begin
            if (b_emit_reg)
            begin
                wr_ptr_reg <= wr_ptr_reg + FP'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FP'(1);
            end
            fifo_count_reg <= fifo_count_reg + FC'(b_emit_reg) - FC'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_emit_reg)
        begin
            fifo_mem[wr_ptr_reg] <= res;
        end
    end

    assign mask_valid   = (fifo_count_reg != '0);
    assign motion       = fifo_mem[rd_ptr_reg].motion;
    assign end_of_frame = fifo_mem[rd_ptr_reg].eof;

endmodule

`default_nettype wire

// File: rtl/mmnf_line_store.sv
`default_nettype none

module mmnf_line_store
    import mmnf_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
)
(
    input  wire logic         clk,
    input  wire logic         rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output line_pair_t        rd_data,
    input  wire logic         wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  line_pair_t        wr_data
);

    line_pair_t mem [DEPTH];
    line_pair_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/mmnf_cell.sv
`default_nettype none

module mmnf_cell
    import mmnf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  cell_ctrl_t ctrl,
    input  col_t       col_in,
    input  col_t       row_mask,
    output col_t       col_out,
    output logic [1:0] count
);

    col_t col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            col_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;
    assign count   = popcount3(col_reg & row_mask);

endmodule

`default_nettype wire

// File: rtl/mmnf_checker.sv
`default_nettype none

module mmnf_checker
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic pixel_valid,
    input wire logic pixel_stall,
    input wire logic mask_valid,
    input wire logic mask_stall,
    input wire logic motion,
    input wire logic end_of_frame
);

    logic pix_acc;

    assign pix_acc = pixel_valid && !pixel_stall;

    a_mask_hold: assert property (@(posedge clk) disable iff (!rst_n)
        mask_valid && mask_stall |=> mask_valid)
        else $error("mask word withdrawn while stalled");

    a_mask_stable: assert property (@(posedge clk) disable iff (!rst_n)
        mask_valid && mask_stall |=> $stable(motion) && $stable(end_of_frame))
        else $error("mask word changed while stalled");

    a_stall_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> mask_valid)
        else $error("pixel stall with no mask word waiting");

    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(mask_valid) |-> $past(pix_acc, 2))
        else $error("mask word without a pixel word two cycles earlier");

endmodule

bind motion_mask_neighbour_filter mmnf_checker u_mmnf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .mask_valid   (mask_valid),
    .mask_stall   (mask_stall),
    .motion       (motion),
    .end_of_frame (end_of_frame)
);

`default_nettype wire
